/* rtl/pngu_pkg.sv */
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and codes for the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
package pngu_pkg;

    // row filter codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // highest legal filter code
    localparam logic [7:0] FILT_MAX = 8'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_HAS_ALPHA    = 2'd2;

    localparam int CFG_DATA_W = 15;

    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

    // one output word
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } result_t;

endpackage

/* rtl/pngu_ram.sv */
// ----------------------------------------------------------------------------
// pngu_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/pngu_predict.sv */
// ----------------------------------------------------------------------------
// pngu_predict
// PNG row predictor: rebuilds one sample from the raw byte and the left,
// above and above-left neighbors, modulo 256.
// ----------------------------------------------------------------------------
module pngu_predict (
    input  logic [2:0] filter,
    input  logic [7:0] raw,
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  logic [7:0] c,
    output logic [7:0] value
);

    logic signed [9:0] sa, sb, sc;
    logic signed [9:0] da, db, dc;
    logic [9:0]        pa, pb, pc;
    logic [7:0]        paeth;
    logic [8:0]        sum_ab;
    logic [7:0]        avg;

    // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
    always_comb
    begin
        sa = $signed({2'b00, a});
        sb = $signed({2'b00, b});
        sc = $signed({2'b00, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
        begin
            paeth = a;
        end
        else if (pb <= pc)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end
        sum_ab = {1'b0, a} + {1'b0, b};
        avg    = sum_ab[8:1];
    end

    always_comb
    begin
        case (filter)
            pngu_pkg::FILT_SUB:   value = raw + a;
            pngu_pkg::FILT_UP:    value = raw + b;
            pngu_pkg::FILT_AVG:   value = raw + avg;
            pngu_pkg::FILT_PAETH: value = raw + paeth;
            default:              value = raw;
        endcase
    end

endmodule

/* rtl/png_scanline_unfilter_bgra_unit.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_bgra_unit
// PNG scanline unfilter for 8-bit RGB / RGBA, BGRA pixel output.
// ----------------------------------------------------------------------------
// Takes one inflated stream byte per cycle while the skid word is empty: every
// byte is rebuilt in the cycle it is accepted and any resulting pixel word is
// registered into the output buffer. The rate is set by the previous-row
// line store, a registered-read RAM whose read address always tracks the
// column of the next sample byte, so the above byte is ready when that byte
// arrives. The first byte of each row is the filter code (0..4); a code above
// 4 yields one word with bad_filter set and the block then drops bytes until
// the next frame_start. Bytes past the last row are dropped. The line store is
// not cleared after reset; it is only read on rows below the first, at
// columns already written by the row above. A two-word output buffer lets the
// block keep taking bytes while a finished word waits on out_ready.
// Configuration must be written only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_bgra_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write_en,
    input  logic [1:0]                      cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      raw_byte,
    input  logic                            frame_start,
    // output stream
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      blue,
    output logic [7:0]                      green,
    output logic [7:0]                      red,
    output logic [7:0]                      alpha,
    output logic                            row_end,
    output logic                            image_end,
    output logic                            bad_filter
);

    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int RAM_AW      = $clog2(STORE_DEPTH);

    // ---------------- configuration ----------------
    logic [12:0] image_width_reg;
    logic [14:0] image_height_reg;
    logic        has_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 13'd1;
            image_height_reg <= 15'd1;
            has_alpha_reg    <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                pngu_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                pngu_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[14:0];
                pngu_pkg::CFG_HAS_ALPHA:    has_alpha_reg    <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // effective geometry: zero counts as one, width clamps to MAX_WIDTH
    logic [12:0] eff_width;
    logic [14:0] eff_height;
    logic [15:0] row_len;

    always_comb
    begin
        if (image_width_reg == 13'd0)
        begin
            eff_width = 13'd1;
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            eff_width = 13'(MAX_WIDTH);
        end
        else
        begin
            eff_width = image_width_reg;
        end
        eff_height = (image_height_reg == 15'd0) ? 15'd1 : image_height_reg;
        // width * 4 or width * 3, no multiplier needed
        row_len = has_alpha_reg ? {1'b0, eff_width, 2'b00}
                                : ({2'b00, eff_width, 1'b0} + {3'b000, eff_width});
    end

    // ---------------- unfilter state ----------------
    logic [3:0][7:0] left_reg,        left_next;
    logic [3:0][7:0] above_left_reg,  above_left_next;
    logic [2:0]      filter_reg,      filter_next;
    logic [14:0]     col_reg,         col_next;
    logic [1:0]      k3_reg,          k3_next;    // byte column mod 3
    logic [14:0]     row_count_reg,   row_count_next;
    logic            expect_reg,      expect_next;
    logic [23:0]     pix_reg,         pix_next;
    logic            failed_reg,      failed_next;

    // line store
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // predictor hookup
    logic [7:0] nb_a, nb_b, nb_c;
    logic [7:0] rebuilt;

    logic              in_fire;
    logic              res_valid;
    pngu_pkg::result_t res;

    // state as seen after an optional frame_start clear
    logic        cur_failed;
    logic        cur_expect;
    logic [14:0] cur_row_count;
    logic [1:0]  lane;
    logic        last_lane;
    logic        col_in_store;
    logic [14:0] col_inc;
    logic        row_done;
    logic [23:0] pix_upd;
    logic [7:0]  alpha_upd;

    assign in_fire = in_valid & in_ready;

    // data bytes never carry frame_start (that byte is a filter byte), so the
    // neighbor reads come straight from the registers
    always_comb
    begin
        lane         = has_alpha_reg ? col_reg[1:0] : k3_reg;
        last_lane    = has_alpha_reg ? (lane == 2'd3) : (lane == 2'd2);
        col_in_store = 32'(col_reg) < STORE_DEPTH;
        nb_a         = left_reg[lane];
        nb_c         = above_left_reg[lane];
        nb_b         = (row_count_reg != 15'd0 && col_in_store) ? ram_rdata : 8'd0;
        col_inc      = col_reg + 15'd1;
        row_done     = {1'b0, col_inc} >= row_len;
    end

    pngu_predict u_predict (
        .filter (filter_reg),
        .raw    (raw_byte),
        .a      (nb_a),
        .b      (nb_b),
        .c      (nb_c),
        .value  (rebuilt)
    );

    always_comb
    begin
        left_next       = left_reg;
        above_left_next = above_left_reg;
        filter_next     = filter_reg;
        col_next        = col_reg;
        k3_next         = k3_reg;
        row_count_next  = row_count_reg;
        expect_next     = expect_reg;
        pix_next        = pix_reg;
        failed_next     = failed_reg;
        ram_we          = 1'b0;
        ram_waddr       = RAM_AW'(col_reg);
        ram_wdata       = rebuilt;
        res_valid       = 1'b0;
        res             = '0;
        cur_failed      = failed_reg;
        cur_expect      = expect_reg;
        cur_row_count   = row_count_reg;
        pix_upd         = pix_reg;
        alpha_upd       = pngu_pkg::OPAQUE_ALPHA;

        if (in_fire)
        begin
            if (frame_start)
            begin
                left_next       = '0;
                above_left_next = '0;
                filter_next     = pngu_pkg::FILT_NONE;
                col_next        = 15'd0;
                k3_next         = 2'd0;
                row_count_next  = 15'd0;
                expect_next     = 1'b1;
                pix_next        = 24'd0;
                failed_next     = 1'b0;
                cur_failed      = 1'b0;
                cur_expect      = 1'b1;
                cur_row_count   = 15'd0;
            end

            if (!cur_failed && cur_row_count < eff_height)
            begin
                if (cur_expect)
                begin
                    if (raw_byte > pngu_pkg::FILT_MAX)
                    begin
                        failed_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.bad_filter = 1'b1;
                    end
                    else
                    begin
                        filter_next     = raw_byte[2:0];
                        expect_next     = 1'b0;
                        col_next        = 15'd0;
                        k3_next         = 2'd0;
                        pix_next        = 24'd0;
                        left_next       = '0;
                        above_left_next = '0;
                    end
                end
                else
                begin
                    above_left_next[lane] = nb_b;
                    left_next[lane]       = rebuilt;
                    ram_we                = col_in_store;
                    col_next              = col_inc;
                    // mod-3 tracker, kept exact across the 15-bit wrap
                    if (col_inc == 15'd0 || k3_reg == 2'd2)
                    begin
                        k3_next = 2'd0;
                    end
                    else
                    begin
                        k3_next = k3_reg + 2'd1;
                    end

                    case (lane)
                        2'd0:    pix_upd[7:0]   = rebuilt;
                        2'd1:    pix_upd[15:8]  = rebuilt;
                        2'd2:    pix_upd[23:16] = rebuilt;
                        default: alpha_upd      = rebuilt;
                    endcase
                    pix_next = pix_upd;

                    if (row_done)
                    begin
                        expect_next    = 1'b1;
                        row_count_next = row_count_reg + 15'd1;
                    end

                    if (last_lane)
                    begin
                        res_valid     = 1'b1;
                        res.blue      = pix_upd[23:16];
                        res.green     = pix_upd[15:8];
                        res.red       = pix_upd[7:0];
                        res.alpha     = alpha_upd;
                        res.row_end   = row_done;
                        res.image_end = row_done && (row_count_next >= eff_height);
                        pix_next      = 24'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            above_left_reg <= '0;
            filter_reg     <= pngu_pkg::FILT_NONE;
            col_reg        <= 15'd0;
            k3_reg         <= 2'd0;
            row_count_reg  <= 15'd0;
            expect_reg     <= 1'b1;
            pix_reg        <= 24'd0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            left_reg       <= left_next;
            above_left_reg <= above_left_next;
            filter_reg     <= filter_next;
            col_reg        <= col_next;
            k3_reg         <= k3_next;
            row_count_reg  <= row_count_next;
            expect_reg     <= expect_next;
            pix_reg        <= pix_next;
            failed_reg     <= failed_next;
        end
    end

    // read address follows the next column, so data is ready for the next byte;
    // it never equals the column being written in the same cycle
    pngu_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (RAM_AW'(col_next)),
        .rdata (ram_rdata)
    );

    // ---------------- output buffer: main word + skid word ----------------
    pngu_pkg::result_t out_reg,  skid_reg;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              out_take;
    logic              load_out_res, load_out_skid, load_skid;

    assign in_ready = !skid_valid_reg;
    assign out_take = out_valid_reg & out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_res    = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (res_valid)
        begin
            if (out_valid_reg && !out_ready)
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
            else
            begin
                load_out_res   = 1'b1;
                out_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                load_out_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_res)
        begin
            out_reg <= res;
        end
        else if (load_out_skid)
        begin
            out_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign blue       = out_reg.blue;
    assign green      = out_reg.green;
    assign red        = out_reg.red;
    assign alpha      = out_reg.alpha;
    assign row_end    = out_reg.row_end;
    assign image_end  = out_reg.image_end;
    assign bad_filter = out_reg.bad_filter;

    // ---------------- assertions ----------------
    // skid word only ever sits behind a held main word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word valid while main word empty");

    // a bad filter word always leaves the block in the failed state
    a_bad_sets_failed: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.bad_filter) |=> failed_reg)
        else $error("bad filter word without failed state");

    // last pixel of the image is also the last of its row
    a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.image_end) |-> out_reg.row_end)
        else $error("image_end without row_end");

    // a finished row always goes back to waiting for a filter byte
    a_row_done_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.row_end) |=> expect_reg)
        else $error("row ended but no filter byte expected");

endmodule
